// ----- src/lbd_pkg.sv -----
// Shared widths, codes and sizes for the Lagrange basis derivative evaluator.
package lbd_pkg;

    localparam int COORD_W       = 32;
    localparam int COORD_FRAC    = 30;
    localparam int VALUE_W       = 48;
    localparam int VALUE_FRAC    = 32;
    localparam int IDX_W         = 3;
    localparam int ORDER_W       = 2;
    localparam int COUNT_W       = 4;
    localparam int DEF_MAX_NODES = 8;
    localparam int RESULT_SLOTS  = 8;

    // Exact intermediate values live in nine 32-bit limbs.
    localparam int LIMB_W  = 32;
    localparam int LIMBS   = 9;
    localparam int WIDE_W  = LIMB_W * LIMBS;
    localparam int DEN_ROW = 8;
    localparam int ROWS    = 9;
    localparam int MEM_AW  = $clog2(ROWS * LIMBS);

    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } func_t;

endpackage

// ----- src/lbd_if.sv -----
// Valid/ready channel interfaces for items and results.
interface lbd_in_if
    import lbd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [IDX_W-1:0]          node_index;
    logic signed [COORD_W-1:0] coordinate;
    logic [ORDER_W-1:0]        deriv_order;

    modport source (output valid, func, node_index, coordinate, deriv_order, input ready);
    modport sink   (input valid, func, node_index, coordinate, deriv_order, output ready);
endinterface

interface lbd_out_if
    import lbd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          basis_index;
    logic signed [VALUE_W-1:0] basis_value;
    logic                      saturated;
    logic                      bad_nodes;
    logic                      last;

    modport source (output valid, basis_index, basis_value, saturated, bad_nodes, last,
                     input ready);
    modport sink   (input valid, basis_index, basis_value, saturated, bad_nodes, last,
                     output ready);
endinterface

// ----- src/lagrange_basis_derivative_eval.sv -----
// Lagrange basis value and derivative evaluator, top level.
//
//   channel   dir   beat contents
//   item      in    func, node_index, coordinate (Q2.30), deriv_order
//   result    out   basis_index, basis_value (Q16.32), saturated, bad_nodes, last
//   cfg_wr    in    node_count (4 bits), written when cfg_wr_en is high
//
// The evaluation time is set by the shared 32x33 multiply-add, which walks nine
// limbs of the coefficient memory, and by the 49-step shift-subtract divider per
// basis function. Reset clears control state only; the node table is undefined
// until loaded. item.ready is high only while idle. A stalled result holds the
// sequencer in its output state, and the final result may wait in the output
// register while the next item is taken.
module lagrange_basis_derivative_eval
    import lbd_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    lbd_in_if.sink             item,
    lbd_out_if.source          result
);

    localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int N_LIM   = (MAX_NODES < RESULT_SLOTS) ? MAX_NODES : RESULT_SLOTS;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_BASIS = 12'b000000000010,
        S_NODE  = 12'b000000000100,
        S_DEN   = 12'b000000001000,
        S_EPASS = 12'b000000010000,
        S_LOAD  = 12'b000000100000,
        S_SCALE = 12'b000001000000,
        S_SHIFT = 12'b000010000000,
        S_ABS   = 12'b000100000000,
        S_PREP  = 12'b001000000000,
        S_DIV   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    // Control state.
    state_t             state_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   t_reg;
    logic [3:0]         w_reg;
    logic [5:0]         bit_reg;

    // Datapath state.
    logic signed [COORD_W-1:0] node_reg [MAX_NODES];
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] xi_reg;
    logic [ORDER_W-1:0]        k_reg;
    logic [COUNT_W-1:0]        n_reg;
    logic signed [COORD_W:0]   d_reg;
    logic signed [COORD_W:0]   dd_reg;
    logic                      bad_reg;
    logic signed [35:0]        carry_reg;
    logic [WIDE_W-1:0]         num_reg;
    logic [WIDE_W-1:0]         den_reg;
    logic [VALUE_W-1:0]        q_reg;
    logic                      ovf_reg;
    logic                      neg_reg;

    logic [IDX_W-1:0]          out_idx_reg;
    logic signed [VALUE_W-1:0] out_val_reg;
    logic                      out_sat_reg;
    logic                      out_bad_reg;
    logic                      out_last_reg;

    // Coefficient memory: rows 0..7 hold the elementary symmetric sums, row 8 the
    // denominator product, each as nine little-endian limbs.
    logic [LIMB_W-1:0] coef_mem [ROWS * LIMBS];
    logic [LIMB_W-1:0] rd_a_reg;
    logic [LIMB_W-1:0] rd_b_reg;

    function automatic logic [MEM_AW-1:0] maddr(input logic [3:0] row, input logic [3:0] limb);
        maddr = MEM_AW'(int'(row) * LIMBS + int'(limb));
    endfunction

    logic                      in_fire;
    logic [COUNT_W-1:0]        n_calc;
    logic [COUNT_W-1:0]        m_val;
    logic [COUNT_W-1:0]        num_row;
    logic                      k_big;
    logic                      j_last;
    logic                      i_last;
    logic                      force_zero;
    logic [NODE_AW-1:0]        node_addr;
    logic signed [COORD_W-1:0] node_rd;
    logic signed [COORD_W:0]   d_new;
    logic signed [COORD_W:0]   dd_new;

    logic [3:0]                src_row;
    logic [3:0]                dst_row;
    logic                      a_one;
    logic                      b_zero;
    logic signed [COORD_W:0]   mult;
    logic [3:0]                limb_l;
    logic [3:0]                rd_limb;
    logic [LIMB_W-1:0]         a_val;
    logic [LIMB_W-1:0]         b_val;
    logic signed [65:0]        prod;
    logic signed [67:0]        acc;
    logic                      mem_we;

    logic [WIDE_W:0]           diff;
    logic                      ge;
    logic                      out_load;
    logic [VALUE_W-1:0]        res_val;
    logic                      res_sat;

    assign in_fire      = item.valid && item.ready;
    assign item.ready   = (state_reg == S_IDLE);

    always_comb
    begin
        if (count_reg < COUNT_W'(2))
            n_calc = COUNT_W'(2);
        else if (count_reg > COUNT_W'(N_LIM))
            n_calc = COUNT_W'(N_LIM);
        else
            n_calc = count_reg;
    end

    assign m_val      = n_reg - COUNT_W'(1);
    assign k_big      = COUNT_W'(k_reg) > m_val;
    assign num_row    = m_val - COUNT_W'(k_reg);
    assign j_last     = (COUNT_W'(j_reg) == m_val);
    assign i_last     = (COUNT_W'(i_reg) == m_val);
    assign force_zero = bad_reg || k_big;

    assign node_addr = (state_reg == S_BASIS) ? NODE_AW'(i_reg) : NODE_AW'(j_reg);
    assign node_rd   = node_reg[node_addr];
    assign d_new     = (COORD_W + 1)'(x_reg) - (COORD_W + 1)'(node_rd);
    assign dd_new    = (COORD_W + 1)'(xi_reg) - (COORD_W + 1)'(node_rd);

    // Operand routing for the shared multiply-add unit.
    always_comb
    begin
        src_row = 4'(DEN_ROW);
        dst_row = 4'(DEN_ROW);
        a_one   = 1'b0;
        b_zero  = 1'b1;
        mult    = dd_reg;
        case (state_reg)
            S_DEN:
            begin
                a_one = (cnt_reg == IDX_W'(1));
            end
            S_EPASS:
            begin
                src_row = 4'(t_reg - IDX_W'(1));
                dst_row = 4'(t_reg);
                a_one   = (t_reg == IDX_W'(1));
                b_zero  = (t_reg == cnt_reg);
                mult    = d_reg;
            end
            S_LOAD:
            begin
                src_row = num_row;
                a_one   = (num_row == 4'd0);
            end
            default:
            begin
            end
        endcase
    end

    assign limb_l  = w_reg - 4'd1;
    assign rd_limb = (w_reg < 4'(LIMBS)) ? w_reg : 4'd0;
    assign a_val   = a_one ? ((limb_l == 4'd0) ? LIMB_W'(1) : '0) : rd_a_reg;
    assign b_val   = b_zero ? '0 : rd_b_reg;
    assign prod    = $signed({1'b0, a_val}) * mult;
    assign acc     = 68'(prod) + $signed({36'd0, b_val}) + 68'(carry_reg);
    assign mem_we  = ((state_reg == S_DEN) || (state_reg == S_EPASS)) && (w_reg != 4'd0);

    // One restoring division step per cycle.
    assign diff = {1'b0, num_reg} - {1'b0, den_reg};
    assign ge   = !diff[WIDE_W];

    // Sign, saturation and the forced-zero cases on the rounded quotient.
    always_comb
    begin
        res_sat = 1'b0;
        res_val = q_reg;
        if (force_zero)
        begin
            res_val = '0;
        end
        else if (!neg_reg)
        begin
            res_sat = ovf_reg || q_reg[VALUE_W-1];
            if (res_sat)
                res_val = {1'b0, {(VALUE_W - 1){1'b1}}};
        end
        else
        begin
            res_sat = ovf_reg || (q_reg[VALUE_W-1] && (q_reg[VALUE_W-2:0] != '0));
            if (res_sat)
                res_val = {1'b1, {(VALUE_W - 1){1'b0}}};
            else
                res_val = '0 - q_reg;
        end
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= COUNT_W'(2);
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            t_reg         <= '0;
            w_reg         <= '0;
            bit_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && (item.func == FUNC_EVAL))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_BASIS;
                    end
                end
                S_BASIS:
                begin
                    j_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_NODE;
                end
                S_NODE:
                begin
                    w_reg <= '0;
                    if (j_reg == i_reg)
                    begin
                        if (j_last)
                            state_reg <= force_zero ? S_OUT : S_LOAD;
                        else
                            j_reg <= j_reg + IDX_W'(1);
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + IDX_W'(1);
                        t_reg     <= cnt_reg + IDX_W'(1);
                        state_reg <= S_DEN;
                    end
                end
                S_DEN:
                begin
                    if (w_reg == 4'(LIMBS))
                    begin
                        w_reg     <= '0;
                        state_reg <= S_EPASS;
                    end
                    else
                        w_reg <= w_reg + 4'd1;
                end
                S_EPASS:
                begin
                    if (w_reg == 4'(LIMBS))
                    begin
                        w_reg <= '0;
                        if (t_reg == IDX_W'(1))
                        begin
                            if (j_last)
                                state_reg <= force_zero ? S_OUT : S_LOAD;
                            else
                            begin
                                j_reg     <= j_reg + IDX_W'(1);
                                state_reg <= S_NODE;
                            end
                        end
                        else
                            t_reg <= t_reg - IDX_W'(1);
                    end
                    else
                        w_reg <= w_reg + 4'd1;
                end
                S_LOAD:
                begin
                    if (w_reg == 4'(LIMBS))
                        state_reg <= S_SCALE;
                    else
                        w_reg <= w_reg + 4'd1;
                end
                S_SCALE:
                begin
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    state_reg <= S_ABS;
                end
                S_ABS:
                begin
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    bit_reg   <= 6'(VALUE_W);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (bit_reg == 6'd0)
                        state_reg <= S_OUT;
                    else
                        bit_reg <= bit_reg - 6'd1;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        if (i_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= S_BASIS;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Coefficient memory with registered reads on two ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            coef_mem[maddr(dst_row, limb_l)] <= acc[LIMB_W-1:0];
        rd_a_reg <= coef_mem[maddr(src_row, rd_limb)];
        rd_b_reg <= coef_mem[maddr(dst_row, rd_limb)];
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (item.func == FUNC_LOAD)
                    begin
                        if (int'(item.node_index) < MAX_NODES)
                            node_reg[NODE_AW'(item.node_index)] <= item.coordinate;
                    end
                    else
                    begin
                        x_reg <= item.coordinate;
                        k_reg <= item.deriv_order;
                        n_reg <= n_calc;
                    end
                end
            end
            S_BASIS:
            begin
                xi_reg  <= node_rd;
                bad_reg <= 1'b0;
            end
            S_NODE:
            begin
                if (j_reg != i_reg)
                begin
                    d_reg  <= d_new;
                    dd_reg <= dd_new;
                    if (dd_new == '0)
                        bad_reg <= 1'b1;
                end
            end
            S_DEN, S_EPASS:
            begin
                if (w_reg == 4'd0)
                    carry_reg <= '0;
                else
                    carry_reg <= acc[67:LIMB_W];
            end
            S_LOAD:
            begin
                if (w_reg != 4'd0)
                begin
                    num_reg <= {a_val, num_reg[WIDE_W-1:LIMB_W]};
                    den_reg <= {rd_b_reg, den_reg[WIDE_W-1:LIMB_W]};
                end
            end
            S_SCALE:
            begin
                // Multiply by k factorial.
                neg_reg <= num_reg[WIDE_W-1] ^ den_reg[WIDE_W-1];
                case (k_reg)
                    2'd2:    num_reg <= num_reg << 1;
                    2'd3:    num_reg <= (num_reg << 2) + (num_reg << 1);
                    default: num_reg <= num_reg;
                endcase
            end
            S_SHIFT:
            begin
                case (k_reg)
                    2'd0:    num_reg <= num_reg << VALUE_FRAC;
                    2'd1:    num_reg <= num_reg << (VALUE_FRAC + COORD_FRAC);
                    2'd2:    num_reg <= num_reg << (VALUE_FRAC + 2 * COORD_FRAC);
                    default: num_reg <= num_reg << (VALUE_FRAC + 3 * COORD_FRAC);
                endcase
                den_reg <= den_reg[WIDE_W-1] ? ('0 - den_reg) : den_reg;
            end
            S_ABS:
            begin
                num_reg <= num_reg[WIDE_W-1] ? ('0 - num_reg) : num_reg;
            end
            S_PREP:
            begin
                // Round half away from zero: (2|num| + |den|) / (2|den|).
                num_reg <= (num_reg << 1) + den_reg;
                den_reg <= den_reg << (VALUE_W + 1);
                q_reg   <= '0;
                ovf_reg <= 1'b0;
            end
            S_DIV:
            begin
                if (ge)
                    num_reg <= diff[WIDE_W-1:0];
                if (bit_reg == 6'(VALUE_W))
                    ovf_reg <= ge;
                else
                    q_reg <= {q_reg[VALUE_W-2:0], ge};
                den_reg <= den_reg >> 1;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_idx_reg  <= i_reg;
            out_val_reg  <= res_val;
            out_sat_reg  <= res_sat;
            out_bad_reg  <= bad_reg;
            out_last_reg <= i_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.basis_index = out_idx_reg;
    assign result.basis_value = out_val_reg;
    assign result.saturated   = out_sat_reg;
    assign result.bad_nodes   = out_bad_reg;
    assign result.last        = out_last_reg;

endmodule

// ----- src/lbd_checker.sv -----
// Port-level assertions for the Lagrange basis evaluator and their bind.
module lbd_port_checks
    import lbd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               in_func,
    input logic               out_valid,
    input logic               out_ready,
    input logic [IDX_W-1:0]   out_index,
    input logic [VALUE_W-1:0] out_value,
    input logic               out_sat,
    input logic               out_bad,
    input logic               out_last
);

    // An evaluate beat starts a long computation, so the block stops taking items.
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_func == FUNC_EVAL)) |=> !in_ready)
        else $error("item ready stayed high after an evaluate beat");

    // A result for coinciding nodes is forced to zero and never clipped.
    a_bad_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_bad) |-> (!out_sat && (out_value == '0)))
        else $error("bad-node result is not a clean zero");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_value) && $stable(out_index)))
        else $error("result beat changed while stalled");

    // Only the final result of an evaluation can still be waiting once the
    // block takes items again.
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> !in_ready)
        else $error("item ready while a non-final result is pending");

endmodule

bind lagrange_basis_derivative_eval lbd_port_checks u_lbd_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_func   (item.func),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_index (result.basis_index),
    .out_value (result.basis_value),
    .out_sat   (result.saturated),
    .out_bad   (result.bad_nodes),
    .out_last  (result.last)
);

// ----- test/lbd_checker.sv -----
// Checker that predicts and compares the basis results of the evaluator.
`timescale 1ns / 100ps

module lbd_checker
    import lbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    lbd_in_if                  item,
    lbd_out_if                 result,
    output int                 fail_count,
    output int                 pending
);

    typedef logic signed [383:0] wide_t;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
        logic               sat;
        logic               bad;
        logic               last;
    } basis_result_t;

    logic signed [COORD_W-1:0] node_pos [RESULT_SLOTS];
    logic [COUNT_W-1:0]        node_count;
    basis_result_t             basis_q [$];

    // Exact rational value of the k-th derivative of basis i at x, rounded once.
    function automatic logic [VALUE_W-1:0] basis_at(input int i, input int n,
                                                    input logic signed [COORD_W-1:0] x,
                                                    input int k, output logic sat,
                                                    output logic bad);
        wide_t sym [RESULT_SLOTS];
        wide_t den, num, q, diff, dd, lim;
        int    cnt, m;
        logic  neg;
        sat = 1'b0;
        bad = 1'b0;
        cnt = 0;
        m   = n - 1;
        lim = wide_t'(1) <<< 47;
        for (int t = 0; t < RESULT_SLOTS; t++)
        begin
            sym[t] = (t == 0) ? wide_t'(1) : wide_t'(0);
        end
        den = wide_t'(1);
        for (int j = 0; j < n; j++)
        begin
            if (j != i)
            begin
                dd = wide_t'(node_pos[i]) - wide_t'(node_pos[j]);
                if (dd == 0)
                    bad = 1'b1;
                den  = den * dd;
                diff = wide_t'(x) - wide_t'(node_pos[j]);
                cnt++;
                for (int t = cnt; t >= 1; t--)
                begin
                    sym[t] = sym[t] + sym[t-1] * diff;
                end
            end
        end
        if (bad || k > m)
            return '0;
        num = sym[m-k] * ((k == 3) ? 6 : (k == 2) ? 2 : 1);
        num = num <<< (30 * k + 32);
        neg = num[383] != den[383];
        if (num < 0)
            num = -num;
        if (den < 0)
            den = -den;
        if (num == 0)
            return '0;
        q = (2 * num + den) / (2 * den);
        if (!neg)
        begin
            if (q > lim - 1)
            begin
                sat = 1'b1;
                q   = lim - 1;
            end
            return q[VALUE_W-1:0];
        end
        if (q > lim)
        begin
            sat = 1'b1;
            q   = lim;
        end
        q = -q;
        return q[VALUE_W-1:0];
    endfunction

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        $display("mismatch %s: expected %h got %h at %0t", field, want, got, $time);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        basis_result_t want;
        int            n;
        if (!rst_n)
        begin
            node_count = 4'd2;
            basis_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                node_count = cfg_wr_data;
            if (item.valid && item.ready)
            begin
                if (item.func == FUNC_LOAD)
                    node_pos[item.node_index] = item.coordinate;
                else
                begin
                    // The count register is clamped to the table size.
                    n = (node_count < 2) ? 2 : (node_count > 8) ? 8 : int'(node_count);
                    for (int i = 0; i < n; i++)
                    begin
                        want.idx   = IDX_W'(i);
                        want.value = basis_at(i, n, item.coordinate, int'(item.deriv_order),
                                              want.sat, want.bad);
                        want.last  = (i == n - 1);
                        basis_q.push_back(want);
                    end
                end
            end
            if (result.valid && result.ready)
            begin
                if (basis_q.size() == 0)
                    report("unexpected beat", 64'd0, 64'(result.basis_index));
                else
                begin
                    want = basis_q.pop_front();
                    if (result.basis_index !== want.idx)
                        report("basis_index", 64'(want.idx), 64'(result.basis_index));
                    if (result.basis_value !== want.value)
                        report("basis_value", 64'(want.value), 64'(result.basis_value));
                    if (result.saturated !== want.sat)
                        report("saturated", 64'(want.sat), 64'(result.saturated));
                    if (result.bad_nodes !== want.bad)
                        report("bad_nodes", 64'(want.bad), 64'(result.bad_nodes));
                    if (result.last !== want.last)
                        report("last", 64'(want.last), 64'(result.last));
                end
            end
            pending = basis_q.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the Lagrange basis derivative evaluator: stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import lbd_pkg::*;

    // Cycles without any accepted beat before the run is declared hung. This
    // leaves a wide margin over an eight-node evaluation together with the
    // long receiver hold-off.
    localparam int HANG_LIMIT = 20000;
    localparam int ONE_Q      = 32'h4000_0000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;
    int                 fail_count;
    int                 pending;

    lbd_in_if  item();
    lbd_out_if result();

    lagrange_basis_derivative_eval u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .result      (result)
    );

    lbd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .result      (result),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The stimulus keeps its own copy of the node slots so that it can
    // aim loads at coinciding or nearly coinciding nodes.
    logic signed [COORD_W-1:0] slot_copy [RESULT_SLOTS];
    bit                        offering;
    int                        burst_left;

    // Offers one beat and returns at the edge where it is taken. Between
    // bursts the valid line drops for a random gap.
    task automatic send(input func_t f, input int idx, input int coord, input int order);
        item.valid       <= 1'b1;
        item.func        <= f;
        item.node_index  <= IDX_W'(idx);
        item.coordinate  <= coord;
        item.deriv_order <= ORDER_W'(order);
        offering = 1'b1;
        do
            @(posedge clk);
        while (!item.ready);
        if (f == FUNC_LOAD)
            slot_copy[idx] = coord;
        burst_left--;
        if (burst_left <= 0)
        begin
            item.valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 4))
                @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    // The count register may only change while the block is idle, so every
    // expected result must be in and the block given time to settle. The task
    // first waits on the clock so that the checker has counted the last beat taken.
    task automatic set_count(input int cnt);
        if (offering)
            item.valid <= 1'b0;
        offering = 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(cnt);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0:       return -ONE_Q;
            1:       return ONE_Q;
            default: return int'($urandom_range(32'h8000_0000, 0) - ONE_Q);
        endcase
    endfunction

    // Loads lean toward coinciding and adjacent nodes, which exercise the
    // bad-node flag and saturation.
    task automatic rand_load();
        int slot;
        int other;
        slot  = $urandom_range(0, 7);
        other = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
            0, 1:    send(FUNC_LOAD, slot, slot_copy[other], 0);
            2:       send(FUNC_LOAD, slot, slot_copy[other] + 1, 0);
            default: send(FUNC_LOAD, slot, rand_coord(), 0);
        endcase
    endtask

    initial
    begin
        int phase_cnt;
        int phase_len;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        item.valid       = 1'b0;
        item.func        = FUNC_LOAD;
        item.node_index  = '0;
        item.coordinate  = '0;
        item.deriv_order = '0;
        offering   = 1'b0;
        burst_left = 4;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Every slot is written before the first evaluation so
        // that no unloaded node is ever read.
        send(FUNC_LOAD, 0, 0, 0);
        send(FUNC_LOAD, 1, 1, 0);
        send(FUNC_LOAD, 2, -ONE_Q, 0);
        send(FUNC_LOAD, 3, ONE_Q, 0);
        send(FUNC_LOAD, 4, 32'h1234_5678 - ONE_Q, 0);
        send(FUNC_LOAD, 5, -32'h0ABC_DEF1, 0);
        send(FUNC_LOAD, 6, 32'h2AAA_AAAA, 0);
        send(FUNC_LOAD, 7, -32'h3555_5555, 0);
        set_count(2);
        // Adjacent nodes: values and first derivatives clip at both bounds, higher orders are zero.
        for (int k = 0; k < 4; k++)
            send(FUNC_EVAL, 0, (k[0]) ? ONE_Q : -ONE_Q, k);
        set_count(3);
        send(FUNC_LOAD, 2, 0, 0);
        send(FUNC_EVAL, 0, ONE_Q, 0);
        send(FUNC_EVAL, 0, 12345, 2);
        send(FUNC_LOAD, 2, -ONE_Q, 0);
        set_count(0);
        send(FUNC_EVAL, 0, ONE_Q / 2, 1);
        set_count(15);
        send(FUNC_EVAL, 0, ONE_Q, 3);
        send(FUNC_EVAL, 0, -ONE_Q, 0);

        // Random phases: mostly small node counts, a few extreme ones.
        for (int p = 0; p < 18; p++)
        begin
            case ($urandom_range(0, 19))
                0:       phase_cnt = $urandom_range(0, 1);
                1:       phase_cnt = $urandom_range(9, 15);
                2, 3:    phase_cnt = $urandom_range(6, 8);
                4, 5, 6: phase_cnt = 5;
                default: phase_cnt = $urandom_range(2, 4);
            endcase
            set_count(phase_cnt);
            phase_len = (phase_cnt >= 6 || phase_cnt > 8) ? 8 : 17;
            for (int it = 0; it < phase_len; it++)
            begin
                if ($urandom_range(0, 9) < 3)
                    rand_load();
                else
                    send(FUNC_EVAL, $urandom_range(0, 7), rand_coord(), $urandom_range(0, 3));
            end
        end

        if (offering)
            item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("lagrange_basis_derivative_eval regression: pass");
        else
            $display("lagrange_basis_derivative_eval regression: fail");
        $finish;
    end

    // Result side. The receiver alternates between open stretches, a random
    // bit pattern and short stalls. Once, well into the run and while the
    // sender is offering, it holds off for a long stretch so that the block
    // backs up and refuses new items.
    initial
    begin
        int         cyc;
        int         mode;
        bit         held;
        logic [31:0] pat;
        result.ready = 1'b0;
        cyc  = 0;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 9);
            if (!held && cyc > 3000 && offering)
            begin
                held = 1'b1;
                result.ready <= 1'b0;
                repeat (1500) @(posedge clk);
                cyc += 1500;
            end
            else if (mode < 4)
            begin
                result.ready <= 1'b1;
                repeat ($urandom_range(1, 64)) @(posedge clk);
                cyc += 32;
            end
            else if (mode < 8)
            begin
                pat = $urandom;
                for (int b = 0; b < 32; b++)
                begin
                    result.ready <= pat[b];
                    @(posedge clk);
                end
                cyc += 32;
            end
            else
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
                cyc += 15;
            end
        end
    end

    // Watchdog: a run that stops moving beats is a failure.
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("lagrange_basis_derivative_eval regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
